FILE: hw/rtl/buddy_memory_allocator_top_assert.svh
// assertion macros for the buddy allocator checker
// used by bma_checker.sv, no other dependencies
`ifndef BUDDY_MEMORY_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_MEMORY_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BMA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator assertion failed");

// next-cycle implication, disabled during reset
`define BMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator assertion failed");

// next-cycle implication that also holds across reset
`define BMA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("buddy allocator assertion failed");

`endif

FILE: hw/rtl/bma_pkg.sv
// shared types, widths and elaboration helpers of the buddy allocator
// no dependencies
package bma_pkg;

   localparam int SIZE_W = 16;
   localparam int OFF_W  = 10;
   localparam int ORD_W  = 5;

   // request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // floor of log2, -1 for zero (elaboration only)
   function automatic int floor_log2(input int v);
      int r;
      r = -1;
      while (v > 0) begin
         v = v >> 1;
         r = r + 1;
      end
      return r;
   endfunction

   // total slots of all per-order circular queues
   function automatic int store_depth(input int nunits);
      int acc;
      int n;
      acc = 0;
      n = nunits;
      while (n > 0) begin
         acc = acc + n;
         n = n >> 1;
      end
      return acc;
   endfunction

   // datapath operations
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_SCAN_NEXT,
      DP_POP,
      DP_SPLIT,
      DP_FREE_PUSH,
      DP_ROT_START,
      DP_ROT_STEP,
      DP_FAIL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic above_top;
      logic cnt_zero;
      logic at_order;
      logic try_merge;
      logic hit;
      logic rot_last;
   } dp_stat_type;

endpackage

FILE: hw/rtl/bma_if.sv
// request and response channel interfaces of the buddy allocator
// depends on bma_pkg
interface bma_req_if;
   import bma_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [SIZE_W-1:0] req_size;
   logic [OFF_W-1:0]  free_offset;
   modport source (output valid, op, req_size, free_offset, input ready);
   modport sink (input valid, op, req_size, free_offset, output ready);
endinterface

interface bma_rsp_if;
   import bma_pkg::*;
   logic             valid;
   logic             ready;
   logic [OFF_W-1:0] alloc_offset;
   logic             failed;
   modport source (output valid, alloc_offset, failed, input ready);
   modport sink (input valid, alloc_offset, failed, output ready);
endinterface

FILE: hw/rtl/bma_datapath.sv
// buddy allocator datapath: queue memory, heads, counts, order and offsets
// depends on bma_pkg
module bma_datapath #(
   parameter int MEM_BYTES  = 1024,
   parameter int UNIT_BYTES = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bma_pkg::SIZE_W-1:0] req_size,
   input  logic [bma_pkg::OFF_W-1:0]  free_offset,
   input  bma_pkg::dp_cmd_type        cmd,
   output bma_pkg::dp_stat_type       stat,
   output logic [bma_pkg::OFF_W-1:0]  alloc_offset,
   output logic                       failed
);
   import bma_pkg::*;

   localparam int NUNITS = MEM_BYTES / UNIT_BYTES;
   localparam int TOP    = floor_log2(NUNITS);
   localparam int NQ     = (TOP < 0) ? 1 : TOP + 1;
   localparam int KW     = (NQ > 1) ? $clog2(NQ) : 1;
   localparam int UW     = $clog2(NUNITS + 2);
   localparam int SD0    = store_depth(NUNITS);
   localparam int SD     = (SD0 < 1) ? 1 : SD0;
   localparam int AW     = (SD > 1) ? $clog2(SD) : 1;
   localparam int VW     = $clog2(MEM_BYTES + 1024);
   localparam int LB     = floor_log2(UNIT_BYTES);

   // queue storage
   logic [VW-1:0] queue_mem [SD];
   logic [VW-1:0] rdata_ff;

   logic [ORD_W-1:0] k_ff, k_in, ord_ff, ord_in;
   logic [VW-1:0]    off_ff, off_in, res_ff, res_in;
   logic             fail_ff, fail_in;
   logic [UW-1:0]    j_ff, j_in, n_ff, n_in;
   logic [UW-1:0]    head_ff [NQ];
   logic [UW-1:0]    head_in [NQ];
   logic [UW-1:0]    cnt_ff [NQ];
   logic [UW-1:0]    cnt_in [NQ];
   logic [OFF_W-1:0] alloc_offset_ff, alloc_offset_in;
   logic             failed_ff, failed_in;

   // size to order
   logic [SIZE_W-1:0] sz_m1;
   logic [ORD_W-1:0]  ceil_lg;
   logic [ORD_W-1:0]  req_order;
   always_comb begin
      sz_m1 = (req_size == '0) ? '0 : req_size - SIZE_W'(1);
      ceil_lg = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (sz_m1[i]) ceil_lg = ORD_W'(i + 1);
      end
      req_order = (int'(ceil_lg) > LB) ? ORD_W'(int'(ceil_lg) - LB) : '0;
   end

   // per-order base and capacity constants
   logic [AW-1:0] base_c [NQ];
   logic [UW-1:0] cap_c [NQ];
   always_comb begin
      int acc;
      acc = 0;
      for (int i = 0; i < NQ; i++) begin
         cap_c[i]  = UW'(NUNITS >> i);
         base_c[i] = AW'(acc);
         acc = acc + (NUNITS >> i);
      end
   end

   // selected queue
   logic [KW-1:0] kidx;
   logic [UW-1:0] cap_k, head_k, cnt_k, head_next;
   logic [AW-1:0] base_k, rd_addr, wr_addr;
   logic [UW:0]   tail_sum;
   logic [UW-1:0] tail_slot;
   logic [VW-1:0] bytes, buddy;
   logic          has_room;
   assign kidx      = k_ff[KW-1:0];
   assign cap_k     = cap_c[kidx];
   assign base_k    = base_c[kidx];
   assign head_k    = head_ff[kidx];
   assign cnt_k     = cnt_ff[kidx];
   assign head_next = (head_k + UW'(1) == cap_k) ? '0 : head_k + UW'(1);
   assign tail_sum  = {1'b0, head_k} + {1'b0, cnt_k};
   assign tail_slot = (tail_sum >= {1'b0, cap_k}) ? UW'(tail_sum - {1'b0, cap_k})
                                                  : UW'(tail_sum);
   assign rd_addr   = base_k + AW'(head_k);
   assign wr_addr   = base_k + AW'(tail_slot);
   assign bytes     = VW'(UNIT_BYTES) << k_ff;
   assign buddy     = off_ff ^ bytes;
   assign has_room  = cnt_k < cap_k;

   // status to controller
   always_comb begin
      stat.above_top = int'(k_ff) > TOP;
      stat.cnt_zero  = cnt_k == '0;
      stat.at_order  = k_ff == ord_ff;
      stat.try_merge = (int'(k_ff) < TOP) && (buddy < VW'(MEM_BYTES)) && (cnt_k != '0);
      stat.hit       = rdata_ff == buddy;
      stat.rot_last  = (j_ff + UW'(1)) == n_ff;
   end

   // memory write port
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [VW-1:0] mem_wd;
   always_comb begin
      mem_we = 1'b0;
      mem_wa = wr_addr;
      mem_wd = off_ff;
      if (reset) begin
         mem_we = (TOP >= 0);
         mem_wa = base_c[NQ-1];
         mem_wd = '0;
      end else begin
         case (cmd.op)
            DP_SPLIT: begin
               mem_we = has_room;
               mem_wd = res_ff + bytes;
            end
            DP_FREE_PUSH: begin
               mem_we = has_room;
            end
            DP_ROT_STEP: begin
               mem_we = !stat.hit;
               mem_wd = rdata_ff;
            end
            default: mem_we = 1'b0;
         endcase
      end
   end

   // memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[mem_wa] <= mem_wd;
      rdata_ff <= queue_mem[rd_addr];
   end

   // next-state of queue control and working registers
   always_comb begin
      k_in    = k_ff;
      ord_in  = ord_ff;
      off_in  = off_ff;
      res_in  = res_ff;
      fail_in = fail_ff;
      j_in    = j_ff;
      n_in    = n_ff;
      head_in = head_ff;
      cnt_in  = cnt_ff;
      alloc_offset_in = alloc_offset_ff;
      failed_in       = failed_ff;
      case (cmd.op)
         DP_LOAD: begin
            k_in    = req_order;
            ord_in  = req_order;
            off_in  = VW'(free_offset);
            res_in  = '0;
            fail_in = 1'b0;
         end
         DP_SCAN_NEXT: k_in = k_ff + ORD_W'(1);
         DP_POP: begin
            head_in[kidx] = head_next;
            cnt_in[kidx]  = cnt_k - UW'(1);
            res_in        = rdata_ff;
            k_in          = k_ff - ORD_W'(1);
         end
         DP_SPLIT: begin
            if (has_room) cnt_in[kidx] = cnt_k + UW'(1);
            k_in = k_ff - ORD_W'(1);
         end
         DP_FREE_PUSH: begin
            if (has_room) cnt_in[kidx] = cnt_k + UW'(1);
         end
         DP_ROT_START: begin
            n_in = cnt_k;
            j_in = '0;
         end
         DP_ROT_STEP: begin
            head_in[kidx] = head_next;
            if (stat.hit) begin
               cnt_in[kidx] = cnt_k - UW'(1);
               off_in       = off_ff & ~bytes;
               k_in         = k_ff + ORD_W'(1);
            end else begin
               j_in = j_ff + UW'(1);
            end
         end
         DP_FAIL: fail_in = 1'b1;
         default: k_in = k_ff;
      endcase
      if (cmd.rsp_load) begin
         alloc_offset_in = res_ff[OFF_W-1:0];
         failed_in       = fail_ff;
      end
   end

   // queue control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= (TOP >= 0 && i == NQ - 1) ? UW'(1) : '0;
         end
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      ord_ff  <= ord_in;
      off_ff  <= off_in;
      res_ff  <= res_in;
      fail_ff <= fail_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      alloc_offset_ff <= alloc_offset_in;
      failed_ff       <= failed_in;
   end

   assign alloc_offset = alloc_offset_ff;
   assign failed       = failed_ff;

endmodule

FILE: hw/rtl/bma_controller.sv
// buddy allocator controller: sequences alloc scan, split and free merge
// depends on bma_pkg
module bma_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bma_pkg::dp_stat_type stat,
   output bma_pkg::dp_cmd_type  cmd
);
   import bma_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_A_SCAN  = 9'b000000010,
      ST_A_POP   = 9'b000000100,
      ST_A_SPLIT = 9'b000001000,
      ST_F_CHK   = 9'b000010000,
      ST_F_ROT   = 9'b000100000,
      ST_F_WAIT  = 9'b001000000,
      ST_F_PUSH  = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.op       = DP_NONE;
      cmd.rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = (req_op == OP_FREE) ? ST_F_CHK : ST_A_SCAN;
            end
         end
         ST_A_SCAN: begin
            if (stat.above_top) begin
               cmd.op   = DP_FAIL;
               state_in = ST_DONE;
            end else if (stat.cnt_zero) begin
               cmd.op = DP_SCAN_NEXT;
            end else begin
               state_in = ST_A_POP;
            end
         end
         ST_A_POP: begin
            cmd.op   = DP_POP;
            state_in = stat.at_order ? ST_DONE : ST_A_SPLIT;
         end
         ST_A_SPLIT: begin
            cmd.op = DP_SPLIT;
            if (stat.at_order) state_in = ST_DONE;
         end
         ST_F_CHK: begin
            if (stat.above_top) begin
               state_in = ST_DONE;
            end else if (stat.try_merge) begin
               cmd.op   = DP_ROT_START;
               state_in = ST_F_ROT;
            end else begin
               cmd.op   = DP_FREE_PUSH;
               state_in = ST_DONE;
            end
         end
         ST_F_ROT: begin
            cmd.op = DP_ROT_STEP;
            if (stat.hit) state_in = ST_F_CHK;
            else if (stat.rot_last) state_in = ST_F_PUSH;
            else state_in = ST_F_WAIT;
         end
         ST_F_WAIT: state_in = ST_F_ROT;
         ST_F_PUSH: begin
            cmd.op   = DP_FREE_PUSH;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/buddy_memory_allocator_top.sv
// Buddy allocator over MEM_BYTES bytes in UNIT_BYTES units, one FIFO free
// queue per order. Request channel req_chan carries op (0 allocate, 1 free),
// req_size in bytes and free_offset; response channel rsp_chan returns
// alloc_offset and failed, one beat per request, in request order.
// One request is worked on at a time: req_chan.ready is high only while idle.
// An allocate scans upward past each empty order, pops the first non-empty
// queue and then splits down to the requested order; a failed allocate ends
// once the scan passes the top order. A free examines queue entries one by
// one in the buddy searches of every order it merges through, with a wait
// state between queue memory reads, then pushes the block into its queue.
// A finished result sits in the output register until rsp_chan.ready. While
// it waits, one more request may be accepted and worked; that one then holds
// in the done state, and no further request is accepted until the waiting
// beat is taken.
// Reset (synchronous) empties all queues but the top order, which holds
// offset 0; the queue memory is not cleared, only that slot is written.
module buddy_memory_allocator_top #(
   parameter int MEM_BYTES  = 1024,
   parameter int UNIT_BYTES = 4
) (
   input logic        clock,
   input logic        reset,
   bma_req_if.sink    req_chan,
   bma_rsp_if.source  rsp_chan
);
   import bma_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   bma_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_op    (req_chan.op),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // queues and working registers
   bma_datapath #(
      .MEM_BYTES  (MEM_BYTES),
      .UNIT_BYTES (UNIT_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_size     (req_chan.req_size),
      .free_offset  (req_chan.free_offset),
      .cmd          (cmd),
      .stat         (stat),
      .alloc_offset (rsp_chan.alloc_offset),
      .failed       (rsp_chan.failed)
   );

endmodule

FILE: hw/rtl/bma_checker.sv
// port-level checker of the buddy allocator and its bind to the top level
// depends on bma_pkg and buddy_memory_allocator_top_assert.svh
`include "buddy_memory_allocator_top_assert.svh"

module bma_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bma_pkg::OFF_W-1:0] alloc_offset,
   input logic                      failed
);
   import bma_pkg::*;

   // one request at a time
   `BMA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   // failed beat carries zero offset
   `BMA_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && failed, alloc_offset == '0)
   // stalled response beat stays
   `BMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // no response right after reset
   `BMA_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid && req_ready)

endmodule

bind buddy_memory_allocator_top bma_checker u_bma_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .alloc_offset (rsp_chan.alloc_offset),
   .failed       (rsp_chan.failed)
);
